// ===== sv/assert_macros.svh =====
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while reset is released.
`define ASSERT_SYNC(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_SYNC(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== sv/stbs_pkg.sv =====
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int IDX_BITS       = 10;
  localparam int KEY_BITS       = 32;
  localparam int CFG_BITS       = 11;
  localparam int IN_TDATA_BITS  = 96;
  localparam int OUT_TDATA_BITS = 16;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  // Sign-extend a 32-bit field, then wrap it to the table word width.
  function automatic value_t value_of(logic [KEY_BITS-1:0] f);
    logic signed [63:0] ext;
    ext = 64'(signed'(f));
    return ext[VALUE_BITS-1:0];
  endfunction

  // Clamp an interval bound to the last table position.
  function automatic addr_t sat_index(logic [IDX_BITS-1:0] i);
    if (32'(i) > TABLE_DEPTH - 1) begin
      return ADDR_BITS'(TABLE_DEPTH - 1);
    end
    return ADDR_BITS'(i);
  endfunction

  // Position of the last entry in use: zero counts as one, clamp to depth.
  function automatic addr_t last_index(logic [CFG_BITS-1:0] n);
    logic [31:0] m;
    m = 32'(n);
    if (m == 32'd0) begin
      m = 32'd1;
    end
    if (m > 32'(TABLE_DEPTH)) begin
      m = 32'(TABLE_DEPTH);
    end
    return ADDR_BITS'(m - 32'd1);
  endfunction

  function automatic logic [IDX_BITS-1:0] to_pos(addr_t m);
    logic [31:0] w;
    w = 32'(m);
    return w[IDX_BITS-1:0];
  endfunction

endpackage

// ===== sv/stbs_ram.sv =====
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tuser: req_type; tdata: write/search fields
// out_     out  out_tvalid/out_tready tuser: found; tdata: position
// cfg_     in   cfg_wr_en            cfg_wr_data: entries_in_use
//
// A write word is stored in the table RAM at acceptance.
// A search reads the first entry and then the last entry in use for the range check,
// then runs the halving steps with one RAM read and compare each, until a hit or an
// empty interval. The single RAM port allows one read per cycle.
// Input is taken only between searches; a finished result waits in the output
// register while the next word is accepted. Reset clears control state only.
`include "assert_macros.svh"

module sorted_table_binary_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] write_index, [41:10] entry_value, [73:42] search_key,
  // [83:74] low_index, [93:84] high_index, [95:94] zero
  input  logic [stbs_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  // [0] req_type
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] position, [15:10] zero
  output logic [stbs_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  // [0] found
  output logic                                out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [stbs_pkg::CFG_BITS-1:0]       cfg_wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LAST  = 3'd1;
  localparam logic [2:0] S_RANGE = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int AB = stbs_pkg::ADDR_BITS;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [stbs_pkg::CFG_BITS-1:0] cfg_r;

  logic signed [stbs_pkg::VALUE_BITS-1:0] key_r, key_nxt;
  logic signed [stbs_pkg::VALUE_BITS-1:0] first_r, first_nxt;
  logic [AB:0]   lo_r, lo_nxt;
  logic [AB-1:0] hi_r, hi_nxt;
  logic [AB-1:0] mid_r, mid_nxt;
  logic [AB-1:0] last_r, last_nxt;
  logic          res_found_r, res_found_nxt;
  logic [AB-1:0] res_pos_r, res_pos_nxt;
  logic          out_found_r, out_found_nxt;
  logic [stbs_pkg::IDX_BITS-1:0] out_pos_r, out_pos_nxt;

  logic                              ram_we;
  logic [AB-1:0]                     ram_addr;
  logic [stbs_pkg::VALUE_BITS-1:0]   ram_wdata;
  logic [stbs_pkg::VALUE_BITS-1:0]   ram_rdata;
  logic signed [stbs_pkg::VALUE_BITS-1:0] rd_val;

  logic [stbs_pkg::IDX_BITS-1:0] f_write_index, f_low_index, f_high_index;
  logic [stbs_pkg::KEY_BITS-1:0] f_entry_value, f_search_key;

  logic          in_fire;
  logic [AB:0]   lo_step, sum;
  logic [AB-1:0] hi_step;
  logic          go_on;

  assign f_write_index = in_tdata[9:0];
  assign f_entry_value = in_tdata[41:10];
  assign f_search_key  = in_tdata[73:42];
  assign f_low_index   = in_tdata[83:74];
  assign f_high_index  = in_tdata[93:84];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {{(stbs_pkg::OUT_TDATA_BITS - stbs_pkg::IDX_BITS){1'b0}}, out_pos_r};
  assign rd_val     = signed'(ram_rdata);

  stbs_ram #(
    .WIDTH (stbs_pkg::VALUE_BITS),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    last_nxt      = last_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    ram_we        = 1'b0;
    ram_addr      = mid_r;
    ram_wdata     = stbs_pkg::value_of(f_entry_value);
    lo_step       = lo_r;
    hi_step       = hi_r;
    go_on         = 1'b0;
    sum           = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == stbs_pkg::REQ_SEARCH) begin
            key_nxt   = signed'(stbs_pkg::value_of(f_search_key));
            lo_nxt    = {1'b0, stbs_pkg::sat_index(f_low_index)};
            hi_nxt    = stbs_pkg::sat_index(f_high_index);
            last_nxt  = stbs_pkg::last_index(cfg_r);
            ram_addr  = '0;
            state_nxt = S_LAST;
          end else if (32'(f_write_index) < stbs_pkg::TABLE_DEPTH) begin
            ram_we   = 1'b1;
            ram_addr = AB'(f_write_index);
          end
        end
      end
      S_LAST: begin
        first_nxt = rd_val;
        ram_addr  = last_r;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        // key must lie between the first entry and the last entry in use, and the interval must not be empty
        res_found_nxt = 1'b0;
        res_pos_nxt   = '0;
        if (key_r >= first_r && key_r <= rd_val && lo_r <= {1'b0, hi_r}) begin
          sum       = lo_r + {1'b0, hi_r};
          mid_nxt   = sum[AB:1];
          ram_addr  = sum[AB:1];
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (rd_val == key_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r;
          state_nxt     = S_DONE;
        end else begin
          if (rd_val < key_r) begin
            lo_step = {1'b0, mid_r} + 1'b1;
            go_on   = 1'b1;
          end else if (mid_r != '0) begin
            hi_step = mid_r - 1'b1;
            go_on   = 1'b1;
          end
          lo_nxt = lo_step;
          hi_nxt = hi_step;
          // issue the next probe straight away when the interval is not empty
          if (go_on && lo_step <= {1'b0, hi_step}) begin
            sum      = lo_step + {1'b0, hi_step};
            mid_nxt  = sum[AB:1];
            ram_addr = sum[AB:1];
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_found_r ? stbs_pkg::to_pos(res_pos_r) : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= stbs_pkg::CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    first_r     <= first_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    last_r      <= last_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  `ASSERT_SYNC(a_search_starts, (in_fire && in_tuser == stbs_pkg::REQ_SEARCH) |=> (state_r == S_LAST), "search word did not start the range read")
  `ASSERT_SYNC(a_probe_interval, (state_r == S_CMP) |-> (lo_r <= {1'b0, hi_r}), "probe with an empty interval")
  `ASSERT_SYNC(a_mid_inside, (state_r == S_CMP) |-> ({1'b0, mid_r} >= lo_r && mid_r <= hi_r), "probe position outside the interval")
  `ASSERT_SYNC(a_miss_pos_zero, (out_valid_r && !out_found_r) |-> (out_pos_r == '0), "miss reported with a nonzero position")
  `ASSERT_SYNC(a_done_holds, (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE), "result overwrote a pending word")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic       found;
    logic [9:0] position;
  } lookup_t;

  logic                                clk;
  logic                                rst_n       = 1'b0;
  logic                                in_tvalid   = 1'b0;
  logic                                in_tready;
  logic [stbs_pkg::IN_TDATA_BITS-1:0]  in_tdata    = '0;
  logic                                in_tuser    = stbs_pkg::REQ_WRITE;
  logic                                out_tvalid;
  logic                                out_tready  = 1'b0;
  logic [stbs_pkg::OUT_TDATA_BITS-1:0] out_tdata;
  logic                                out_tuser;
  logic                                cfg_wr_en   = 1'b0;
  logic [stbs_pkg::CFG_BITS-1:0]       cfg_wr_data = '0;

  logic signed [31:0] entry_words [stbs_pkg::TABLE_DEPTH];
  logic [stbs_pkg::CFG_BITS-1:0] entries_in_use_q = stbs_pkg::CFG_RESET;
  lookup_t pending_lookups [$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int writes_sent = 0;
  int lookups_sent = 0;
  int results_seen = 0;
  int lookups_found = 0;

  sorted_table_binary_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls at random in bursts while idle_on is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_lookups.size() == 0) begin
        $error("result word with no lookup pending");
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_tuser !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tuser);
          error_count++;
        end
        if (out_tdata[9:0] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_tdata[9:0]);
          error_count++;
        end
      end
    end
  end

  function automatic int active_entries();
    int n;
    n = int'(entries_in_use_q);
    if (n == 0) n = 1;
    if (n > stbs_pkg::TABLE_DEPTH) n = stbs_pkg::TABLE_DEPTH;
    return n;
  endfunction

  function automatic lookup_t predict_lookup(logic signed [31:0] key, logic [9:0] lo_idx,
                                             logic [9:0] hi_idx);
    lookup_t r;
    int n, lo, hi, mid;
    bit done;
    r = '0;
    n = active_entries();
    lo = int'(lo_idx);
    hi = int'(hi_idx);
    done = 1'b0;
    if (key >= entry_words[0] && key <= entry_words[n-1]) begin
      while (!done && lo <= hi) begin
        mid = (lo + hi) / 2;
        if (entry_words[mid] == key) begin
          r.found = 1'b1;
          r.position = mid[9:0];
          done = 1'b1;
        end else if (entry_words[mid] < key) begin
          lo = mid + 1;
        end else if (mid == 0) begin
          // upper bound would go negative
          done = 1'b1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_word(logic kind, logic [stbs_pkg::IN_TDATA_BITS-1:0] data);
    int gap;
    lookup_t r;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if (kind == stbs_pkg::REQ_SEARCH) begin
      r = predict_lookup(data[73:42], data[83:74], data[93:84]);
      pending_lookups.push_back(r);
      lookups_found += r.found;
      lookups_sent++;
    end else begin
      entry_words[data[9:0]] = data[41:10];
      writes_sent++;
    end
    @(negedge clk);
  endtask

  // Search fields carry noise on a write, write fields carry noise on a search.
  task automatic write_entry(int idx, logic [31:0] value);
    send_word(stbs_pkg::REQ_WRITE, {2'b00, 10'($urandom), 10'($urandom), 32'($urandom),
                                    value, 10'(idx)});
  endtask

  task automatic lookup(logic [31:0] key, int lo_idx, int hi_idx);
    send_word(stbs_pkg::REQ_SEARCH, {2'b00, 10'(hi_idx), 10'(lo_idx), key, 32'($urandom),
                                     10'($urandom)});
  endtask

  // Hold input, drain all results, then let the block go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_entries_in_use(logic [stbs_pkg::CFG_BITS-1:0] n);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    entries_in_use_q = n;
  endtask

  task automatic random_lookup();
    int n, sel, a, b, t;
    logic [31:0] key;
    n = active_entries();
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      key = entry_words[$urandom_range(0, n - 1)];
    end else if (sel < 8) begin
      key = entry_words[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
    end else begin
      key = $urandom();
    end
    a = $urandom_range(0, stbs_pkg::TABLE_DEPTH - 1);
    b = $urandom_range(0, stbs_pkg::TABLE_DEPTH - 1);
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      a = 0;
      b = stbs_pkg::TABLE_DEPTH - 1;
    end else if (sel < 5) begin
      a = 0;
      b = n - 1;
    end else if (sel < 8) begin
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
    end else if (sel == 8) begin
      b = a + $urandom_range(0, 3);
      if (b > stbs_pkg::TABLE_DEPTH - 1) b = stbs_pkg::TABLE_DEPTH - 1;
    end
    // otherwise keep the raw draw, which may leave an empty interval
    lookup(key, a, b);
  endtask

  task automatic test_small_table();
    load_entries_in_use(11'd8);
    write_entry(0, -32'sd1000);
    write_entry(1, -32'sd20);
    write_entry(2, -32'sd1);
    write_entry(3, 32'sd0);
    write_entry(4, 32'sd1);
    write_entry(5, 32'sd7);
    write_entry(6, 32'sd300);
    write_entry(7, 32'sd1000);
    write_entry(1023, 32'h7FFF_FFFF);
    write_entry(1022, 32'h8000_0000);
    lookup(32'h8000_0000, 0, 7);   // below first entry
    lookup(32'h7FFF_FFFF, 0, 7);   // above last entry
    lookup(-32'sd1000, 0, 7);
    lookup(32'sd1000, 0, 7);
    lookup(32'sd7, 0, 7);
    lookup(32'sd2, 0, 7);          // in range, absent
    lookup(32'sd0, 5, 2);          // empty interval
    lookup(-32'sd20, 1, 1);
    lookup(32'sd5, 0, 0);
    lookup(-32'sd50, 0, 3);
    // zero entries in use counts as one
    load_entries_in_use(11'd0);
    lookup(-32'sd1000, 0, 7);
    lookup(-32'sd20, 0, 7);
    // oversized count saturates to the full table
    load_entries_in_use(11'd2047);
    lookup(32'sd300, 0, 7);
    lookup(32'h7FFF_FFFF, 0, 7);
    // break the ordering and follow whatever the halving reaches
    write_entry(3, 32'sd5000);
    lookup(32'sd1, 0, 7);
    lookup(32'sd5000, 0, 7);
  endtask

  task automatic test_full_sorted_table();
    longint acc;
    load_entries_in_use(11'd1024);
    acc = -64'sd2147483648 + longint'($urandom_range(0, 1000));
    for (int i = 0; i < stbs_pkg::TABLE_DEPTH; i++) begin
      if (i == stbs_pkg::TABLE_DEPTH - 1) acc = 64'sd2147483647;
      write_entry(i, 32'(acc));
      if ($urandom_range(0, 15) != 0) acc += longint'($urandom_range(1, 8000000));
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    end
    repeat (160) random_lookup();
  endtask

  task automatic test_entry_count_settings();
    logic [stbs_pkg::CFG_BITS-1:0] counts [6];
    counts = '{11'd1, 11'd2, 11'd2047, 11'd1024, 11'(11'($urandom_range(3, 1023))), 11'd512};
    foreach (counts[k]) begin
      load_entries_in_use(counts[k]);
      idle_on = $urandom_range(0, 1);
      repeat (40) random_lookup();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_rewrites();
    int idx;
    longint lo_v, hi_v;
    logic [31:0] v;
    load_entries_in_use(11'(11'($urandom_range(600, 1024))));
    repeat (250) begin
      if ($urandom_range(0, 2) == 0) begin
        idx = $urandom_range(1, stbs_pkg::TABLE_DEPTH - 2);
        lo_v = longint'(entry_words[idx-1]);
        hi_v = longint'(entry_words[idx+1]);
        if ($urandom_range(0, 7) == 0 || hi_v < lo_v) begin
          v = $urandom();
        end else begin
          v = 32'(lo_v + longint'($urandom) % (hi_v - lo_v + 1));
        end
        write_entry(idx, v);
      end else begin
        random_lookup();
      end
    end
  endtask

  task automatic test_back_to_back();
    load_entries_in_use(11'd1024);
    idle_on = 1'b0;
    repeat (100) random_lookup();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_small_table();
    test_full_sorted_table();
    test_entry_count_settings();
    test_rewrites();
    test_back_to_back();
    settle();
    $display("%0d table writes and %0d lookups sent, %0d hits, %0d results checked",
             writes_sent, lookups_sent, lookups_found, results_seen);
    $display("entry counts from zero to saturation, empty and narrow intervals, unsorted data");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/sorted_table_binary_search.sv
test/tb_top.sv
